// File: hdl/segment_box_clearance_check_macros.svh
// Assertion macros for the segment/box clearance checker.
// Used by segment_box_clearance_check.sv; expects clk and rst_n in scope.
`ifndef SEGMENT_BOX_CLEARANCE_CHECK_MACROS_SVH
`define SEGMENT_BOX_CLEARANCE_CHECK_MACROS_SVH

// Same-cycle implication
`define SBCC_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SBCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/sbcc_pkg.sv
// Shared widths, error codes and helpers for the segment/box clearance checker.
// No dependencies.
`timescale 1ns / 1ps

package sbcc_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int ABS_W   = SUM_W - 1;
    localparam int DSQ_W   = 2 * COORD_W;
    localparam int ERR_W   = 2;

    typedef logic [ERR_W-1:0] err_t;

    localparam err_t ERR_NONE  = 2'd0;
    localparam err_t ERR_COORD = 2'd1;
    localparam err_t ERR_BOX   = 2'd2;
    localparam err_t ERR_DIST  = 2'd3;

    // sign-extend a coordinate by one bit
    function automatic logic signed [DIFF_W-1:0] ext1(input logic signed [COORD_W-1:0] c);
        return $signed({c[COORD_W-1], c});
    endfunction

    // difference of two coordinates, never overflows
    function automatic logic signed [DIFF_W-1:0] cdiff(input logic signed [COORD_W-1:0] a,
                                                       input logic signed [COORD_W-1:0] b);
        return ext1(a) - ext1(b);
    endfunction

endpackage

// File: hdl/sbcc_wmul.sv
// Two-stage wide unsigned multiplier: four half-width partial products, then sum.
// No dependencies.
`timescale 1ns / 1ps

module sbcc_wmul #(
    parameter int A_W = 67,
    parameter int B_W = 67
) (
    input  logic               clk,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic [A_W+B_W-1:0] p
);

    localparam int AL = A_W / 2;
    localparam int AH = A_W - AL;
    localparam int BL = B_W / 2;
    localparam int BH = B_W - BL;
    localparam int P_W = A_W + B_W;

    logic [AL+BL-1:0] ll_reg;
    logic [AH+BL-1:0] hl_reg;
    logic [AL+BH-1:0] lh_reg;
    logic [AH+BH-1:0] hh_reg;
    logic [P_W-1:0]   p_reg;
    logic [P_W-1:0]   p_next;

    // partial products
    always_ff @(posedge clk)
    begin
        ll_reg <= a[AL-1:0] * b[BL-1:0];
        hl_reg <= a[A_W-1:AL] * b[BL-1:0];
        lh_reg <= a[AL-1:0] * b[B_W-1:BL];
        hh_reg <= a[A_W-1:AL] * b[B_W-1:BL];
    end

    // recombine
    always_comb
    begin
        p_next = (P_W'(hh_reg) << (AL + BL)) + (P_W'(hl_reg) << AL)
               + (P_W'(lh_reg) << BL) + P_W'(ll_reg);
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

// File: hdl/segment_box_clearance_check.sv
// An accepted request (start high) runs through every stage below and the final decision register to its done strobe.
// Throughput: one request per cycle; busy is held low, every stage advances each cycle.
// The depth is set by the squared perpendicular distance test, which runs through a
// two-stage split multiplier after four stages of differences, products, sums and magnitudes.
// Reset clears the valid pipeline and sets min_clearance to 0; results cannot be stalled.
`timescale 1ns / 1ps

module segment_box_clearance_check #(
    parameter int MAX_ABS_COORD = 1073741823
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [sbcc_pkg::COORD_W-1:0] seg_start_x,
    input  logic signed [sbcc_pkg::COORD_W-1:0] seg_start_y,
    input  logic signed [sbcc_pkg::COORD_W-1:0] seg_end_x,
    input  logic signed [sbcc_pkg::COORD_W-1:0] seg_end_y,
    input  logic signed [sbcc_pkg::COORD_W-1:0] box_min_x,
    input  logic signed [sbcc_pkg::COORD_W-1:0] box_min_y,
    input  logic signed [sbcc_pkg::COORD_W-1:0] box_max_x,
    input  logic signed [sbcc_pkg::COORD_W-1:0] box_max_y,
    input  logic                                cfg_we,
    input  logic [sbcc_pkg::COORD_W-1:0]        cfg_wdata,
    output logic                                done,
    output logic [sbcc_pkg::ERR_W-1:0]          error_code,
    output logic                                clearance_ok
);

    import sbcc_pkg::*;

    `include "segment_box_clearance_check_macros.svh"

    localparam int NSTG = 6;

    typedef struct packed {
        err_t err;
        logic zero;
        logic rej;
        logic ins;
        logic xing;
    } ctl_t;

    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    logic signed [DIFF_W-1:0] lim;
    logic [COORD_W-1:0]       min_clearance_reg;
    logic [NSTG-1:0]          vld_reg;

    // ---------------- stage 1: range checks and differences ----------------
    logic signed [COORD_W-1:0] c_in [8];
    logic                      coord_bad;
    err_t                      err_next;
    logic signed [COORD_W-1:0] d_in;

    logic signed [COORD_W-1:0] sx1_reg, sy1_reg, ex1_reg, ey1_reg;
    logic signed [COORD_W-1:0] lox1_reg, loy1_reg, hix1_reg, hiy1_reg, d1_reg;
    err_t                      err1_reg;
    diff_t dx1_reg, dy1_reg;
    diff_t xls1_reg, xhs1_reg, yls1_reg, yhs1_reg;
    diff_t xle1_reg, xhe1_reg, yle1_reg, yhe1_reg;

    assign lim  = DIFF_W'(MAX_ABS_COORD);
    assign d_in = $signed(min_clearance_reg);

    always_comb
    begin
        c_in[0] = seg_start_x;
        c_in[1] = seg_start_y;
        c_in[2] = seg_end_x;
        c_in[3] = seg_end_y;
        c_in[4] = box_min_x;
        c_in[5] = box_min_y;
        c_in[6] = box_max_x;
        c_in[7] = box_max_y;
        coord_bad = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (ext1(c_in[i]) > lim || ext1(c_in[i]) < -lim)
                coord_bad = 1'b1;
        end
        if (coord_bad)
            err_next = ERR_COORD;
        else if (box_min_x > box_max_x || box_min_y > box_max_y)
            err_next = ERR_BOX;
        else if (d_in < 0 || ext1(d_in) > lim)
            err_next = ERR_DIST;
        else
            err_next = ERR_NONE;
    end

    always_ff @(posedge clk)
    begin
        sx1_reg  <= seg_start_x;
        sy1_reg  <= seg_start_y;
        ex1_reg  <= seg_end_x;
        ey1_reg  <= seg_end_y;
        lox1_reg <= box_min_x;
        loy1_reg <= box_min_y;
        hix1_reg <= box_max_x;
        hiy1_reg <= box_max_y;
        d1_reg   <= d_in;
        err1_reg <= err_next;
        dx1_reg  <= cdiff(seg_end_x, seg_start_x);
        dy1_reg  <= cdiff(seg_end_y, seg_start_y);
        xls1_reg <= cdiff(box_min_x, seg_start_x);
        xhs1_reg <= cdiff(box_max_x, seg_start_x);
        yls1_reg <= cdiff(box_min_y, seg_start_y);
        yhs1_reg <= cdiff(box_max_y, seg_start_y);
        xle1_reg <= cdiff(box_min_x, seg_end_x);
        xhe1_reg <= cdiff(box_max_x, seg_end_x);
        yle1_reg <= cdiff(box_min_y, seg_end_y);
        yhe1_reg <= cdiff(box_max_y, seg_end_y);
    end

    // ---------------- stage 2: quick tests and products ----------------
    logic signed [DIFF_W:0] mnx, mxx, mny, mxy;
    logic                   rej_next, ovl_next, ins_next;
    diff_t px [4];
    diff_t py [4];
    diff_t qx [4];
    diff_t qy [4];
    diff_t csx, csy, cex, cey;

    ctl_t  ctl2_reg;
    logic  ovl2_reg;
    prod_t sxx2_reg, syy2_reg;
    prod_t psx2_reg [4];
    prod_t psy2_reg [4];
    prod_t cxp2_reg [4];
    prod_t cyp2_reg [4];
    prod_t pxx2_reg [4];
    prod_t pyy2_reg [4];
    prod_t qxx2_reg [4];
    prod_t qyy2_reg [4];
    prod_t esx2_reg, esy2_reg, eex2_reg, eey2_reg;
    logic signed [DSQ_W-1:0] dd2_reg;

    // distance from a point to the box along one axis, zero when within the span
    function automatic diff_t clampd(input diff_t lo_d, input diff_t hi_d);
        if (lo_d > 0)
            return lo_d;
        else if (hi_d < 0)
            return -hi_d;
        else
            return '0;
    endfunction

    always_comb
    begin
        mnx = (sx1_reg < ex1_reg) ? ext1(sx1_reg) : ext1(ex1_reg);
        mxx = (sx1_reg < ex1_reg) ? ext1(ex1_reg) : ext1(sx1_reg);
        mny = (sy1_reg < ey1_reg) ? ext1(sy1_reg) : ext1(ey1_reg);
        mxy = (sy1_reg < ey1_reg) ? ext1(ey1_reg) : ext1(sy1_reg);
        // segment bounding box at least the clearance away on one axis
        rej_next = (mxx <= ext1(lox1_reg) - ext1(d1_reg)) || (mnx >= ext1(hix1_reg) + ext1(d1_reg))
                || (mxy <= ext1(loy1_reg) - ext1(d1_reg)) || (mny >= ext1(hiy1_reg) + ext1(d1_reg));
        ovl_next = (mxx >= ext1(lox1_reg)) && (mnx <= ext1(hix1_reg))
                && (mxy >= ext1(loy1_reg)) && (mny <= ext1(hiy1_reg));
        ins_next = (xls1_reg <= 0 && xhs1_reg >= 0 && yls1_reg <= 0 && yhs1_reg >= 0)
                || (xle1_reg <= 0 && xhe1_reg >= 0 && yle1_reg <= 0 && yhe1_reg >= 0);
        // corners: lo/lo, hi/lo, hi/hi, lo/hi
        px[0] = xls1_reg; py[0] = yls1_reg; qx[0] = xle1_reg; qy[0] = yle1_reg;
        px[1] = xhs1_reg; py[1] = yls1_reg; qx[1] = xhe1_reg; qy[1] = yle1_reg;
        px[2] = xhs1_reg; py[2] = yhs1_reg; qx[2] = xhe1_reg; qy[2] = yhe1_reg;
        px[3] = xls1_reg; py[3] = yhs1_reg; qx[3] = xle1_reg; qy[3] = yhe1_reg;
        csx = clampd(xls1_reg, xhs1_reg);
        csy = clampd(yls1_reg, yhs1_reg);
        cex = clampd(xle1_reg, xhe1_reg);
        cey = clampd(yle1_reg, yhe1_reg);
    end

    always_ff @(posedge clk)
    begin
        ctl2_reg.err  <= err1_reg;
        ctl2_reg.zero <= (d1_reg == 0);
        ctl2_reg.rej  <= rej_next;
        ctl2_reg.ins  <= ins_next;
        ctl2_reg.xing <= 1'b0;
        ovl2_reg <= ovl_next;
        sxx2_reg <= dx1_reg * dx1_reg;
        syy2_reg <= dy1_reg * dy1_reg;
        for (int k = 0; k < 4; k++)
        begin
            psx2_reg[k] <= px[k] * dx1_reg;
            psy2_reg[k] <= py[k] * dy1_reg;
            cxp2_reg[k] <= dx1_reg * py[k];
            cyp2_reg[k] <= dy1_reg * px[k];
            pxx2_reg[k] <= px[k] * px[k];
            pyy2_reg[k] <= py[k] * py[k];
            qxx2_reg[k] <= qx[k] * qx[k];
            qyy2_reg[k] <= qy[k] * qy[k];
        end
        esx2_reg <= csx * csx;
        esy2_reg <= csy * csy;
        eex2_reg <= cex * cex;
        eey2_reg <= cey * cey;
        dd2_reg  <= d1_reg * d1_reg;
    end

    // ---------------- stage 3: sums and point distance tests ----------------
    sum_t dd_ext;
    ctl_t ctl3_reg;
    logic ovl3_reg;
    sum_t len3_reg;
    sum_t proj3_reg [4];
    sum_t crs3_reg [4];
    logic [3:0] pok3_reg, qok3_reg;
    logic eok3_reg;
    logic [DSQ_W-1:0] dd3_reg;

    assign dd_ext = SUM_W'(dd2_reg);

    always_ff @(posedge clk)
    begin
        ctl3_reg <= ctl2_reg;
        ovl3_reg <= ovl2_reg;
        len3_reg <= SUM_W'(sxx2_reg) + SUM_W'(syy2_reg);
        for (int k = 0; k < 4; k++)
        begin
            proj3_reg[k] <= SUM_W'(psx2_reg[k]) + SUM_W'(psy2_reg[k]);
            crs3_reg[k]  <= SUM_W'(cxp2_reg[k]) - SUM_W'(cyp2_reg[k]);
            pok3_reg[k]  <= (SUM_W'(pxx2_reg[k]) + SUM_W'(pyy2_reg[k])) >= dd_ext;
            qok3_reg[k]  <= (SUM_W'(qxx2_reg[k]) + SUM_W'(qyy2_reg[k])) >= dd_ext;
        end
        eok3_reg <= ((SUM_W'(esx2_reg) + SUM_W'(esy2_reg)) >= dd_ext)
                 && ((SUM_W'(eex2_reg) + SUM_W'(eey2_reg)) >= dd_ext);
        dd3_reg  <= dd2_reg;
    end

    // ---------------- stage 4: corner case split and crossing test ----------------
    logic [3:0] near, far, cpos, cneg, need_next, pre_next;

    // control stays aligned with the two multiplier stages
    ctl_t ctl_reg [NSTG-1:3];
    logic [3:0] need_reg [NSTG-1:3];
    logic pre_reg [NSTG-1:3];
    logic [ABS_W-1:0] abs4_reg [4];
    logic [ABS_W-1:0] len4_reg;
    logic [DSQ_W-1:0] dd4_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            near[k] = (len3_reg == 0) || (proj3_reg[k] <= 0);
            far[k]  = !near[k] && (proj3_reg[k] >= len3_reg);
            cpos[k] = crs3_reg[k] > 0;
            cneg[k] = crs3_reg[k] < 0;
            need_next[k] = !near[k] && !far[k];
            pre_next[k]  = near[k] ? pok3_reg[k] : (far[k] ? qok3_reg[k] : 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        ctl_reg[3].err  <= ctl3_reg.err;
        ctl_reg[3].zero <= ctl3_reg.zero;
        ctl_reg[3].rej  <= ctl3_reg.rej;
        ctl_reg[3].ins  <= ctl3_reg.ins;
        // box corners not all strictly on one side of the segment's line, and bounding boxes overlap
        ctl_reg[3].xing <= ovl3_reg && !(&cpos) && !(&cneg);
        need_reg[3] <= need_next;
        pre_reg[3]  <= (&pre_next) && eok3_reg;
        for (int k = 0; k < 4; k++)
        begin
            abs4_reg[k] <= crs3_reg[k][SUM_W-1] ? ABS_W'(-crs3_reg[k]) : ABS_W'(crs3_reg[k]);
        end
        len4_reg <= ABS_W'(len3_reg);
        dd4_reg  <= dd3_reg;
        for (int s = 4; s <= NSTG - 1; s++)
        begin
            ctl_reg[s]  <= ctl_reg[s-1];
            need_reg[s] <= need_reg[s-1];
            pre_reg[s]  <= pre_reg[s-1];
        end
    end

    // ---------------- stages 5-6: wide squares for the perpendicular test ----------------
    localparam int SQ_W = 2 * ABS_W;
    localparam int DL_W = DSQ_W + ABS_W;

    logic [SQ_W-1:0] sq [4];
    logic [DL_W-1:0] dl;

    for (genvar k = 0; k < 4; k++)
    begin : g_sq
        sbcc_wmul #(.A_W(ABS_W), .B_W(ABS_W)) u_sq (
            .clk (clk),
            .a   (abs4_reg[k]),
            .b   (abs4_reg[k]),
            .p   (sq[k])
        );
    end

    sbcc_wmul #(.A_W(DSQ_W), .B_W(ABS_W)) u_dl (
        .clk (clk),
        .a   (dd4_reg),
        .b   (len4_reg),
        .p   (dl)
    );

    // ---------------- stage 7: final decision ----------------
    logic [3:0] perp_ok;
    logic       ok_next;
    ctl_t       cf;

    logic       done_reg;
    err_t       error_code_reg;
    logic       clearance_ok_reg;

    always_comb
    begin
        cf = ctl_reg[NSTG-1];
        for (int k = 0; k < 4; k++)
        begin
            perp_ok[k] = !need_reg[NSTG-1][k] || (sq[k] >= SQ_W'(dl));
        end
        ok_next = (cf.err == ERR_NONE)
               && (cf.zero || cf.rej
                   || (!cf.ins && !cf.xing && pre_reg[NSTG-1] && (&perp_ok)));
    end

    always_ff @(posedge clk)
    begin
        error_code_reg   <= cf.err;
        clearance_ok_reg <= ok_next;
    end

    // valid pipeline, clearance register, done strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg           <= '0;
            done_reg          <= 1'b0;
            min_clearance_reg <= '0;
        end
        else
        begin
            vld_reg  <= {vld_reg[NSTG-2:0], start};
            done_reg <= vld_reg[NSTG-1];
            if (cfg_we)
                min_clearance_reg <= cfg_wdata;
        end
    end

    assign busy         = 1'b0;
    assign done         = done_reg;
    assign error_code   = error_code_reg;
    assign clearance_ok = clearance_ok_reg;

    // ---------------- assertions ----------------
    `SBCC_ASSERT_IMPLY(a_err_not_ok, done && error_code != ERR_NONE, !clearance_ok, "ok with error")
    `SBCC_ASSERT_IMPLY(a_done_from_pipe, done, $past(vld_reg[NSTG-1]), "done without request")
    `SBCC_ASSERT_NEXT(a_quick_clear, vld_reg[NSTG-1] && cf.err == ERR_NONE && (cf.zero || cf.rej),
                      clearance_ok, "quick reject not clear")

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for segment_box_clearance_check: random and directed
// segment/box requests, exact clearance prediction on 256-bit integers.
// Depends on sbcc_pkg and the segment_box_clearance_check RTL.
`timescale 1ns / 1ps

module tb_top;
    import sbcc_pkg::*;

    localparam longint MAX_C      = 1073741823;
    localparam int     DRAIN_CYC  = 20;
    localparam int     CYCLE_LIM  = 400000;

    typedef logic signed [255:0] wide_t;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic signed [31:0] lx;
        logic signed [31:0] ly;
        logic signed [31:0] hx;
        logic signed [31:0] hy;
    } seg_req_t;

    typedef struct packed {
        err_t err;
        logic ok;
    } verdict_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    seg_req_t           req_bus = '0;
    logic               cfg_we = 1'b0;
    logic [31:0]        cfg_wdata = '0;
    logic               done;
    logic [ERR_W-1:0]   error_code;
    logic               clearance_ok;

    seg_req_t           pending_reqs[$];
    verdict_t           expected_verdicts[$];
    longint             clearance = 0;
    int                 mismatches = 0;
    int                 idle_left = 0;
    bit                 no_idle = 0;
    int                 cycles = 0;
    int                 results_seen = 0;
    int                 ok_seen = 0;
    int                 err_seen[4] = '{0, 0, 0, 0};

    segment_box_clearance_check i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .seg_start_x  (req_bus.sx),
        .seg_start_y  (req_bus.sy),
        .seg_end_x    (req_bus.ex),
        .seg_end_y    (req_bus.ey),
        .box_min_x    (req_bus.lx),
        .box_min_y    (req_bus.ly),
        .box_max_x    (req_bus.hx),
        .box_max_y    (req_bus.hy),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .error_code   (error_code),
        .clearance_ok (clearance_ok)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------- clearance predictor ----------------
    function automatic int wsign(wide_t v);
        return (v < 0) ? -1 : ((v == 0) ? 0 : 1);
    endfunction

    function automatic wide_t wmul(longint a, longint b);
        wide_t wa, wb;
        wa = a;
        wb = b;
        return wa * wb;
    endfunction

    function automatic int orient(longint ax, longint ay, longint bx, longint by,
                                  longint cx, longint cy);
        return wsign(wmul(bx - ax, cy - ay) - wmul(by - ay, cx - ax));
    endfunction

    function automatic bit betw(longint v, longint a, longint b);
        return (v >= ((a < b) ? a : b)) && (v <= ((a < b) ? b : a));
    endfunction

    function automatic bit crosses(longint p1x, longint p1y, longint p2x, longint p2y,
                                   longint q1x, longint q1y, longint q2x, longint q2y);
        int o1, o2, o3, o4;
        o1 = orient(p1x, p1y, p2x, p2y, q1x, q1y);
        o2 = orient(p1x, p1y, p2x, p2y, q2x, q2y);
        o3 = orient(q1x, q1y, q2x, q2y, p1x, p1y);
        o4 = orient(q1x, q1y, q2x, q2y, p2x, p2y);
        if (o1 * o2 < 0 && o3 * o4 < 0)
            return 1;
        return (o1 == 0 && betw(q1x, p1x, p2x) && betw(q1y, p1y, p2y)) ||
               (o2 == 0 && betw(q2x, p1x, p2x) && betw(q2y, p1y, p2y)) ||
               (o3 == 0 && betw(p1x, q1x, q2x) && betw(p1y, q1y, q2y)) ||
               (o4 == 0 && betw(p2x, q1x, q2x) && betw(p2y, q1y, q2y));
    endfunction

    function automatic bit vec_ge(longint x, longint y, longint d);
        return (wmul(x, x) + wmul(y, y)) >= wmul(d, d);
    endfunction

    // squared distance from point p to segment s-e is at least d^2
    function automatic bit pt_seg_ge(longint px, longint py, longint s_x, longint s_y,
                                     longint e_x, longint e_y, longint d);
        longint dx, dy, qx, qy;
        wide_t len2, proj, crs, wd;
        dx = e_x - s_x;
        dy = e_y - s_y;
        qx = px - s_x;
        qy = py - s_y;
        len2 = wmul(dx, dx) + wmul(dy, dy);
        if (len2 == 0)
            return vec_ge(qx, qy, d);
        proj = wmul(qx, dx) + wmul(qy, dy);
        if (proj <= 0)
            return vec_ge(qx, qy, d);
        if (proj >= len2)
            return vec_ge(px - e_x, py - e_y, d);
        crs = wmul(dx, qy) - wmul(dy, qx);
        wd = wmul(d, d);
        return (crs * crs) >= (wd * len2);
    endfunction

    function automatic bit in_box(longint x, longint y, longint lx, longint ly,
                                  longint hx, longint hy);
        return x >= lx && x <= hx && y >= ly && y <= hy;
    endfunction

    function automatic verdict_t predict_clearance(seg_req_t r, longint d);
        verdict_t v;
        longint c[8];
        longint cxs[4], cys[4];
        longint sx, sy, ex, ey, lx, ly, hx, hy;
        int j;
        v.err = ERR_NONE;
        v.ok = 1'b0;
        c[0] = r.sx; c[1] = r.sy; c[2] = r.ex; c[3] = r.ey;
        c[4] = r.lx; c[5] = r.ly; c[6] = r.hx; c[7] = r.hy;
        for (int i = 0; i < 8; i++)
        begin
            if (c[i] < -MAX_C || c[i] > MAX_C)
                v.err = ERR_COORD;
        end
        if (v.err != ERR_NONE)
            return v;
        if (c[4] > c[6] || c[5] > c[7])
        begin
            v.err = ERR_BOX;
            return v;
        end
        if (d < 0 || d > MAX_C)
        begin
            v.err = ERR_DIST;
            return v;
        end
        sx = c[0]; sy = c[1]; ex = c[2]; ey = c[3];
        lx = c[4]; ly = c[5]; hx = c[6]; hy = c[7];
        v.ok = 1'b1;
        if (d == 0)
            return v;
        // bounding reject
        if (((sx > ex) ? sx : ex) <= lx - d || ((sx < ex) ? sx : ex) >= hx + d ||
            ((sy > ey) ? sy : ey) <= ly - d || ((sy < ey) ? sy : ey) >= hy + d)
            return v;
        v.ok = 1'b0;
        if (in_box(sx, sy, lx, ly, hx, hy) || in_box(ex, ey, lx, ly, hx, hy))
            return v;
        cxs = '{lx, hx, hx, lx};
        cys = '{ly, ly, hy, hy};
        for (int i = 0; i < 4; i++)
        begin
            j = (i + 1) & 3;
            if (crosses(sx, sy, ex, ey, cxs[i], cys[i], cxs[j], cys[j]))
                return v;
            if (!pt_seg_ge(sx, sy, cxs[i], cys[i], cxs[j], cys[j], d) ||
                !pt_seg_ge(ex, ey, cxs[i], cys[i], cxs[j], cys[j], d) ||
                !pt_seg_ge(cxs[i], cys[i], sx, sy, ex, ey, d) ||
                !pt_seg_ge(cxs[j], cys[j], sx, sy, ex, ey, d))
                return v;
        end
        v.ok = 1'b1;
        return v;
    endfunction

    // ---------------- request generation ----------------
    function automatic longint clampc(longint v);
        return (v > MAX_C) ? MAX_C : ((v < -MAX_C) ? -MAX_C : v);
    endfunction

    function automatic longint srand(longint span);
        return longint'($urandom_range(0, 32'(2 * span))) - span;
    endfunction

    function automatic seg_req_t mk_req(longint sx, longint sy, longint ex, longint ey,
                                        longint lx, longint ly, longint hx, longint hy);
        seg_req_t r;
        r.sx = 32'(sx); r.sy = 32'(sy); r.ex = 32'(ex); r.ey = 32'(ey);
        r.lx = 32'(lx); r.ly = 32'(ly); r.hx = 32'(hx); r.hy = 32'(hy);
        return r;
    endfunction

    // segment placed around a normalized box, scale chosen near the clearance or from fixed and power-of-two sizes
    function automatic seg_req_t near_req(longint d);
        longint sc, lx, ly, wx, wy;
        case ($urandom_range(0, 4))
            0: sc = 8;
            1: sc = d + 2;
            2: sc = 4 * d + 4;
            3: sc = 1000;
            default: sc = longint'(1) << $urandom_range(10, 29);
        endcase
        if (sc > MAX_C / 2)
            sc = MAX_C / 2;
        lx = clampc(srand(sc));
        ly = clampc(srand(sc));
        wx = $urandom_range(0, 32'(sc));
        wy = $urandom_range(0, 32'(sc));
        return mk_req(clampc(lx + srand(sc + d)), clampc(ly + srand(sc + d)),
                      clampc(lx + srand(sc + d)), clampc(ly + srand(sc + d)),
                      lx, ly, clampc(lx + wx), clampc(ly + wy));
    endfunction

    function automatic seg_req_t random_req(longint d);
        seg_req_t r;
        int pick;
        pick = $urandom_range(0, 99);
        r = near_req(d);
        if (pick < 8)
            r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        else if (pick < 13)
            r = mk_req(r.sx, r.sy, r.ex, r.ey, r.hx + 1, r.ly, r.lx, r.hy);
        else if (pick < 16)
            r = mk_req(r.sx, r.sy, r.ex, r.ey, r.lx, r.hy + 1, r.hx, r.ly);
        else if (pick < 20)
            r.sy = ($urandom_range(0, 1) != 0) ? 32'sd1073741824 : -32'sd1073741824;
        else if (pick < 24)
            r.hx = 32'(($urandom_range(0, 1) != 0) ? MAX_C : -MAX_C);
        return r;
    endfunction

    task automatic queue_directed();
        // extremes of the coordinate range and errors
        pending_reqs.push_back(mk_req(MAX_C, MAX_C, -MAX_C, -MAX_C, -MAX_C, -MAX_C, MAX_C, MAX_C));
        pending_reqs.push_back(mk_req(-MAX_C - 1, 0, 0, 0, 0, 0, 1, 1));
        pending_reqs.push_back(mk_req(0, 0, 0, 0, 0, 0, MAX_C + 1, 1));
        pending_reqs.push_back(mk_req(0, 0, 0, 0, 0, 0, 32'h80000000, 32'h7fffffff));
        pending_reqs.push_back(mk_req(0, 0, 5, 5, 3, 0, 2, 4));
        pending_reqs.push_back(mk_req(0, 0, 5, 5, 0, 3, 4, 2));
        // bounding reject, endpoint inside, edge crossing, touching an edge
        pending_reqs.push_back(mk_req(-20, -20, -20, 30, 0, 0, 10, 10));
        pending_reqs.push_back(mk_req(5, 5, 40, 40, 0, 0, 10, 10));
        pending_reqs.push_back(mk_req(-5, 5, 15, 5, 0, 0, 10, 10));
        pending_reqs.push_back(mk_req(-5, 15, 5, 10, 0, 0, 10, 10));
        pending_reqs.push_back(mk_req(-5, 0, 5, -10, 0, 0, 10, 10));
        // degenerate segments near a corner: distance exactly 5 and just under
        pending_reqs.push_back(mk_req(13, 14, 13, 14, 0, 0, 10, 10));
        pending_reqs.push_back(mk_req(13, 13, 13, 13, 0, 0, 10, 10));
        // diagonal past a corner, exact side distance, point box
        pending_reqs.push_back(mk_req(12, 16, 18, 10, 0, 0, 10, 10));
        pending_reqs.push_back(mk_req(15, -3, 15, 13, 0, 0, 10, 10));
        pending_reqs.push_back(mk_req(4, 4, 8, 0, 0, 0, 0, 0));
        pending_reqs.push_back(mk_req(-MAX_C, MAX_C, MAX_C, -MAX_C, -1, -1, 1, 1));
    endtask

    // ---------------- driver ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            idle_left = 0;
        end
        else if (!(start && busy))
        begin
            if (start)
                expected_verdicts.push_back(predict_clearance(req_bus, clearance));
            if (idle_left > 0)
            begin
                idle_left--;
                start <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                req_bus <= pending_reqs.pop_front();
                start <= 1'b1;
                if (!no_idle && $urandom_range(0, 9) == 0)
                    idle_left = $urandom_range(1, 16);
            end
            else
                start <= 1'b0;
        end
    end

    // ---------------- monitor ----------------
    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && done)
        begin
            if (expected_verdicts.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                want = expected_verdicts.pop_front();
                if (error_code !== want.err)
                    report_mismatch("error_code", error_code, want.err);
                if (clearance_ok !== want.ok)
                    report_mismatch("clearance_ok", clearance_ok, want.ok);
                results_seen++;
                ok_seen += (clearance_ok === 1'b1);
                err_seen[error_code]++;
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIM)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------- sequencing ----------------
    task automatic wait_drained();
        while (pending_reqs.size() > 0 || start || expected_verdicts.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic write_clearance(longint d);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= 32'(d);
        @(posedge clk);
        cfg_we <= 1'b0;
        clearance = longint'($signed(32'(d)));
    endtask

    initial
    begin
        longint settings[10];
        settings = '{5, 1, 0, 100, 1073741823, -1, 1073741824, -2147483648, 37, 4000};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset value of the clearance is zero: everything valid is clear
        queue_directed();
        wait_drained();
        foreach (settings[k])
        begin
            if (k == 8)
                settings[k] = $urandom_range(1, 100000);
            write_clearance(settings[k]);
            if (k < 2)
                queue_directed();
            no_idle = (k == 9);
            for (int n = 0; n < 110; n++)
                pending_reqs.push_back(random_req(clearance));
            // the sender holds until all results of this phase are back
            wait_drained();
        end

        $display("Covered %0d requests over %0d clearance settings: %0d clear,",
                 results_seen, 11, ok_seen);
        $display("errors coord/box/dist = %0d/%0d/%0d", err_seen[1], err_seen[2], err_seen[3]);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: segment_box_clearance_check.f
+incdir+hdl
hdl/sbcc_pkg.sv
hdl/sbcc_wmul.sv
hdl/segment_box_clearance_check.sv
tb/sv/tb_top.sv
